// ===== rtl/nff_pkg.sv =====
package nff_pkg;

    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int CFG_W       = 10;
    localparam int HDR_IDX_W   = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0]     FALLBACK_PAYLOAD = CFG_W'(23 - 3);
    localparam logic [CFG_W-1:0]     HDR_LEN          = CFG_W'(10);
    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX     = HDR_IDX_W'(10);

    localparam logic [BYTE_W-1:0] SYNC_0    = 8'hAA;
    localparam logic [BYTE_W-1:0] SYNC_1    = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_2    = 8'hC3;
    localparam logic [BYTE_W-1:0] PROTO_VER = 8'h01;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PASS,
        F_FRAG,
        F_DROP,
        F_DIV
    } nff_state_t;

    typedef enum logic [1:0] {
        ST_DATA      = 2'd0,
        ST_TOO_LONG  = 2'd1,
        ST_TOO_SMALL = 2'd2
    } nff_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              pend;
        logic              mend;
        nff_status_t       status;
        logic              hdr;
        logic [LEN_W-1:0]  pnum;
        logic [LEN_W-1:0]  ptotal;
        logic [LEN_W-1:0]  length;
    } nff_entry_t;

    function automatic logic [BYTE_W-1:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                                   input nff_entry_t e);
        logic [BYTE_W-1:0] b;
        case (idx)
            4'd0:    b = SYNC_0;
            4'd1:    b = SYNC_1;
            4'd2:    b = SYNC_2;
            4'd3:    b = PROTO_VER;
            4'd4:    b = e.pnum[15:8];
            4'd5:    b = e.pnum[7:0];
            4'd6:    b = e.ptotal[15:8];
            4'd7:    b = e.ptotal[7:0];
            4'd8:    b = e.length[15:8];
            4'd9:    b = e.length[7:0];
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/nff_if.sv =====
interface nff_msg_if import nff_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] msg_byte;
    logic [LEN_W-1:0]  msg_length;

    modport source (output valid, output msg_byte, output msg_length, input ready);
    modport sink   (input valid, input msg_byte, input msg_length, output ready);
endinterface

interface nff_pkt_if import nff_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              packet_end;
    logic              message_end;
    logic [1:0]        status;

    modport source (output valid, output out_byte, output packet_end, output message_end,
                    output status, input ready);
    modport sink   (input valid, input out_byte, input packet_end, input message_end,
                    input status, output ready);
endinterface

// ===== rtl/nff_divider.sv =====
module nff_divider import nff_pkg::*; #(
    parameter int DVD_W = 17,
    parameter int DVS_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    logic [DVS_W:0] trial;
    logic [DVS_W:0] diff;
    logic           ge;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DVD_W-2:0], ge};
            rem_next = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            dvs_reg  <= dvs_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/nff_queue.sv =====
module nff_queue import nff_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  nff_entry_t wr_entry,
    input  logic       pop,
    output nff_entry_t rd_entry,
    output logic       full,
    output logic       empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    nff_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign full     = cnt_reg == CNT_W'(DEPTH);
    assign empty    = cnt_reg == '0;
    assign rd_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("queue pop while empty");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost a push");
`endif

endmodule

// ===== rtl/nff_front.sv =====
module nff_front import nff_pkg::*; #(
    parameter int MAX_MESSAGE_LEN = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    nff_msg_if.sink           msg,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              q_full,
    output logic              push,
    output nff_entry_t        entry,
    output logic              div_start,
    output logic [LEN_W:0]    div_dividend,
    output logic [CFG_W-1:0]  div_divisor,
    input  logic              div_busy,
    input  logic [LEN_W:0]    div_quot
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_MESSAGE_LEN);

    nff_state_t        state_reg, state_next;
    logic [CFG_W-1:0]  psize_reg;
    logic [LEN_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CFG_W-1:0]  chunk_reg, chunk_next;
    logic [CFG_W-1:0]  fill_reg, fill_next;
    logic [LEN_W-1:0]  pnum_reg, pnum_next;
    logic [LEN_W-1:0]  ptot_reg, ptot_next;
    logic [BYTE_W-1:0] first_reg, first_next;

    logic [CFG_W-1:0]  usable;
    logic [CFG_W-1:0]  chunk_new;
    logic              accept;
    logic              len_zero;
    logic              len_one;
    logic              too_long;
    logic              fits;
    logic              too_small;
    logic [LEN_W:0]    pos_inc;
    logic              last;
    logic              at_end;
    logic [CFG_W-1:0]  fill_inc;
    logic              pend_frag;
    logic              first_pend;
    logic              div_ok;

    assign usable     = (psize_reg != '0) ? psize_reg : FALLBACK_PAYLOAD;
    assign chunk_new  = usable - HDR_LEN;
    assign msg.ready  = (state_reg != F_DIV) && !q_full;
    assign accept     = msg.valid && msg.ready;
    assign len_zero   = msg.msg_length == '0;
    assign len_one    = msg.msg_length == LEN_W'(1);
    assign too_long   = msg.msg_length > MAX_LEN;
    assign fits       = msg.msg_length <= LEN_W'(usable);
    assign too_small  = usable <= HDR_LEN;
    assign pos_inc    = {1'b0, pos_reg} + 1'b1;
    assign last       = pos_inc == {1'b0, len_reg};
    assign at_end     = pos_inc >= {1'b0, len_reg};
    assign fill_inc   = fill_reg + 1'b1;
    assign pend_frag  = last || (fill_inc >= chunk_reg);
    assign first_pend = chunk_reg <= CFG_W'(1);
    assign div_ok     = (state_reg == F_DIV) && !div_busy && !q_full;

    assign div_dividend = {1'b0, msg.msg_length} + (LEN_W+1)'(chunk_new) - 1'b1;
    assign div_divisor  = chunk_new;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept && !len_zero)
                begin
                    if (too_long || (!fits && too_small))
                    begin
                        state_next = len_one ? F_IDLE : F_DROP;
                    end
                    else if (fits)
                    begin
                        state_next = len_one ? F_IDLE : F_PASS;
                    end
                    else
                    begin
                        state_next = F_DIV;
                    end
                end
            end
            F_PASS, F_FRAG, F_DROP:
            begin
                if (accept && at_end)
                begin
                    state_next = F_IDLE;
                end
            end
            F_DIV:
            begin
                if (div_ok)
                begin
                    state_next = F_FRAG;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        chunk_next = chunk_reg;
        fill_next  = fill_reg;
        pnum_next  = pnum_reg;
        ptot_next  = ptot_reg;
        first_next = first_reg;
        push       = 1'b0;
        div_start  = 1'b0;
        entry      = '{data: '0, pend: 1'b0, mend: 1'b0, status: ST_DATA, hdr: 1'b0,
                       pnum: pnum_reg, ptotal: ptot_reg, length: len_reg};
        case (state_reg)
            F_IDLE:
            begin
                if (accept && !len_zero)
                begin
                    len_next = msg.msg_length;
                    pos_next = LEN_W'(1);
                    if (too_long || (!fits && too_small))
                    begin
                        push         = 1'b1;
                        entry.mend   = 1'b1;
                        entry.status = too_long ? ST_TOO_LONG : ST_TOO_SMALL;
                    end
                    else if (fits)
                    begin
                        push       = 1'b1;
                        entry.data = msg.msg_byte;
                        entry.pend = len_one;
                        entry.mend = len_one;
                    end
                    else
                    begin
                        chunk_next = chunk_new;
                        first_next = msg.msg_byte;
                        div_start  = 1'b1;
                    end
                end
            end
            F_DIV:
            begin
                if (div_ok)
                begin
                    push         = 1'b1;
                    ptot_next    = div_quot[LEN_W-1:0];
                    entry.data   = first_reg;
                    entry.pend   = first_pend;
                    entry.hdr    = 1'b1;
                    entry.pnum   = '0;
                    entry.ptotal = div_quot[LEN_W-1:0];
                    fill_next    = first_pend ? '0 : CFG_W'(1);
                    pnum_next    = first_pend ? LEN_W'(1) : '0;
                end
            end
            F_PASS:
            begin
                if (accept)
                begin
                    push       = 1'b1;
                    entry.data = msg.msg_byte;
                    entry.pend = last;
                    entry.mend = last;
                    pos_next   = at_end ? '0 : pos_inc[LEN_W-1:0];
                end
            end
            F_FRAG:
            begin
                if (accept)
                begin
                    push       = 1'b1;
                    entry.data = msg.msg_byte;
                    entry.pend = pend_frag;
                    entry.mend = last;
                    entry.hdr  = fill_reg == '0;
                    fill_next  = pend_frag ? '0 : fill_inc;
                    pnum_next  = pend_frag ? pnum_reg + 1'b1 : pnum_reg;
                    pos_next   = at_end ? '0 : pos_inc[LEN_W-1:0];
                end
            end
            F_DROP:
            begin
                if (accept)
                begin
                    pos_next = at_end ? '0 : pos_inc[LEN_W-1:0];
                end
            end
            default: pos_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            psize_reg <= '0;
            pos_reg   <= '0;
            len_reg   <= '0;
            chunk_reg <= '0;
            fill_reg  <= '0;
            pnum_reg  <= '0;
            ptot_reg  <= '0;
            first_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                psize_reg <= cfg_wdata;
            end
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            chunk_reg <= chunk_next;
            fill_reg  <= fill_next;
            pnum_reg  <= pnum_next;
            ptot_reg  <= ptot_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== rtl/nff_back.sv =====
module nff_back import nff_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  nff_entry_t rd_entry,
    input  logic       empty,
    output logic       pop,
    nff_pkt_if.source  pkt
);

    logic                 valid_reg, valid_next;
    logic [BYTE_W-1:0]    byte_reg, byte_next;
    logic                 pend_reg, pend_next;
    logic                 mend_reg, mend_next;
    logic [1:0]           status_reg, status_next;
    logic [HDR_IDX_W-1:0] idx_reg, idx_next;
    logic                 load;
    logic                 in_hdr;

    assign load   = !valid_reg || pkt.ready;
    assign in_hdr = rd_entry.hdr && (idx_reg != HDR_LAST_IDX);

    always_comb
    begin
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        pend_next   = pend_reg;
        mend_next   = mend_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (in_hdr)
                begin
                    byte_next   = hdr_byte(idx_reg, rd_entry);
                    pend_next   = 1'b0;
                    mend_next   = 1'b0;
                    status_next = ST_DATA;
                    idx_next    = idx_reg + 1'b1;
                end
                else
                begin
                    byte_next   = rd_entry.data;
                    pend_next   = rd_entry.pend;
                    mend_next   = rd_entry.mend;
                    status_next = rd_entry.status;
                    idx_next    = '0;
                    pop         = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        pend_reg   <= pend_next;
        mend_reg   <= mend_next;
        status_reg <= status_next;
    end

    assign pkt.valid       = valid_reg;
    assign pkt.out_byte    = byte_reg;
    assign pkt.packet_end  = pend_reg;
    assign pkt.message_end = mend_reg;
    assign pkt.status      = status_reg;

endmodule

// ===== rtl/notify_fragment_framer.sv =====
// Channel   Dir  Handshake      Payload
// msg       in   valid/ready    msg_byte[7:0], msg_length[15:0]
// pkt       out  valid/ready    out_byte[7:0], packet_end, message_end, status[1:0]
// cfg       in   cfg_we         cfg_wdata[9:0] (payload size, 0 selects 20)
//
// Pass-through words move one per cycle while pkt.ready stays high; a fragment chunk of C words leaves C + 10 output
// words, so the output side sets the pace of a fragmented message.
// The first word of a fragmented message waits in the packet-count divider.
// A 2-entry queue separates intake from packet emission; pkt carries a registered stage.
// rst_n clears all control state asynchronously; payload size resets to 0.
module notify_fragment_framer import nff_pkg::*; #(
    parameter int MAX_MESSAGE_LEN = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    nff_msg_if.sink          msg,
    nff_pkt_if.source        pkt,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    nff_entry_t       wr_entry;
    nff_entry_t       rd_entry;
    logic             push;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    logic             div_start;
    logic             div_busy;
    logic [LEN_W:0]   div_dividend;
    logic [CFG_W-1:0] div_divisor;
    logic [LEN_W:0]   div_quot;

    nff_front #(
        .MAX_MESSAGE_LEN (MAX_MESSAGE_LEN)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .msg          (msg),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .q_full       (q_full),
        .push         (push),
        .entry        (wr_entry),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_busy     (div_busy),
        .div_quot     (div_quot)
    );

    nff_divider #(
        .DVD_W (LEN_W + 1),
        .DVS_W (CFG_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    nff_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (rd_entry),
        .full     (q_full),
        .empty    (q_empty)
    );

    nff_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_entry (rd_entry),
        .empty    (q_empty),
        .pop      (pop),
        .pkt      (pkt)
    );

endmodule

// ===== bench/notify_fragment_framer_tb.sv =====
module notify_fragment_framer_tb;
    import nff_pkg::*;

    localparam int MAX_MSG_LEN  = 1024;
    localparam int ITEM_TARGET  = 300;
    localparam int QUIET_LIMIT  = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              pend;
        logic              mend;
        logic [1:0]        status;
    } pkt_word_t;

    class frame_scoreboard;
        pkt_word_t        expected_words[$];
        int               errors;
        logic [CFG_W-1:0] payload_size;
        logic [LEN_W-1:0] byte_pos;
        logic [LEN_W-1:0] msg_len;
        logic [CFG_W-1:0] chunk_size;
        logic [CFG_W-1:0] chunk_fill;
        logic [LEN_W-1:0] pkt_num;
        logic [LEN_W-1:0] pkt_total;
        nff_state_t       mode;

        function new();
            errors       = 0;
            payload_size = '0;
            byte_pos     = '0;
            msg_len      = '0;
            chunk_size   = '0;
            chunk_fill   = '0;
            pkt_num      = '0;
            pkt_total    = '0;
            mode         = F_IDLE;
        endfunction

        function void set_payload(logic [CFG_W-1:0] v);
            payload_size = v;
        endfunction

        function void push(logic [BYTE_W-1:0] b, logic pend, logic mend, nff_status_t st);
            pkt_word_t w;
            w = '{b, pend, mend, st};
            expected_words = {expected_words, w};
        endfunction

        // returns the number of packet words the message word produces
        function int frame_word(logic [BYTE_W-1:0] b, logic [LEN_W-1:0] len);
            int          start_n;
            int          usable;
            int          chunk;
            nff_status_t fault;
            logic        last;
            logic        pend;
            start_n = expected_words.size();
            if (mode == F_IDLE)
            begin
                usable = (payload_size != 0) ? int'(payload_size) : int'(FALLBACK_PAYLOAD);
                fault  = ST_DATA;
                if (len == 0)
                    return 0;
                msg_len  = len;
                byte_pos = '0;
                if (int'(len) > MAX_MSG_LEN)
                    fault = ST_TOO_LONG;
                else if (int'(len) <= usable)
                    mode = F_PASS;
                else if (usable <= int'(HDR_LEN))
                    fault = ST_TOO_SMALL;
                else
                begin
                    mode       = F_FRAG;
                    chunk      = usable - int'(HDR_LEN);
                    chunk_size = CFG_W'(chunk);
                    pkt_total  = LEN_W'((int'(len) + chunk - 1) / chunk);
                    pkt_num    = '0;
                    chunk_fill = '0;
                end
                if (fault != ST_DATA)
                begin
                    push('0, 1'b0, 1'b1, fault);
                    if (len == 1)
                    begin
                        mode     = F_IDLE;
                        byte_pos = '0;
                    end
                    else
                    begin
                        mode     = F_DROP;
                        byte_pos = LEN_W'(1);
                    end
                    return 1;
                end
            end

            last = (int'(byte_pos) + 1 == int'(msg_len));

            if (mode == F_PASS)
                push(b, last, last, ST_DATA);
            else if (mode == F_FRAG)
            begin
                if (chunk_fill == 0)
                begin
                    push(SYNC_0, 1'b0, 1'b0, ST_DATA);
                    push(SYNC_1, 1'b0, 1'b0, ST_DATA);
                    push(SYNC_2, 1'b0, 1'b0, ST_DATA);
                    push(PROTO_VER, 1'b0, 1'b0, ST_DATA);
                    push(pkt_num[15:8], 1'b0, 1'b0, ST_DATA);
                    push(pkt_num[7:0], 1'b0, 1'b0, ST_DATA);
                    push(pkt_total[15:8], 1'b0, 1'b0, ST_DATA);
                    push(pkt_total[7:0], 1'b0, 1'b0, ST_DATA);
                    push(msg_len[15:8], 1'b0, 1'b0, ST_DATA);
                    push(msg_len[7:0], 1'b0, 1'b0, ST_DATA);
                end
                chunk_fill = chunk_fill + 1'b1;
                pend = last || (chunk_fill >= chunk_size);
                push(b, pend, last, ST_DATA);
                if (pend)
                begin
                    chunk_fill = '0;
                    pkt_num    = pkt_num + 1'b1;
                end
            end

            if (last || (int'(byte_pos) + 1 > int'(msg_len)))
            begin
                mode     = F_IDLE;
                byte_pos = '0;
            end
            else
                byte_pos = byte_pos + 1'b1;
            return expected_words.size() - start_n;
        endfunction

        function void check_word(pkt_word_t got);
            pkt_word_t want;
            if (expected_words.size() == 0)
            begin
                $error("unexpected word: out_byte %0h status %0d", got.data, got.status);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            if (got.data !== want.data)
            begin
                $error("out_byte: expected %0h, got %0h", want.data, got.data);
                errors++;
            end
            if (got.pend !== want.pend)
            begin
                $error("packet_end: expected %0b, got %0b", want.pend, got.pend);
                errors++;
            end
            if (got.mend !== want.mend)
            begin
                $error("message_end: expected %0b, got %0b", want.mend, got.mend);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    nff_msg_if msg_ch();
    nff_pkt_if pkt_ch();

    frame_scoreboard sb = new();

    bit calm;
    bit hold_req;
    int items_done;
    int quiet_cycles;

    notify_fragment_framer #(
        .MAX_MESSAGE_LEN(MAX_MSG_LEN)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg_ch),
        .pkt       (pkt_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic idle_msg(int n);
        if (n > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_word(logic [BYTE_W-1:0] b, logic [LEN_W-1:0] len);
        msg_ch.valid      <= 1'b1;
        msg_ch.msg_byte   <= b;
        msg_ch.msg_length <= len;
        do
            @(posedge clk);
        while (!msg_ch.ready);
        void'(sb.frame_word(b, len));
        items_done++;
    endtask

    // later words carry random lengths: only the first one is latched
    task automatic send_message(int len, bit gaps);
        for (int i = 0; i < len; i++)
        begin
            if (gaps)
                idle_msg(rand_gap());
            send_word(BYTE_W'($urandom), (i == 0) ? LEN_W'(len) : LEN_W'($urandom));
        end
    endtask

    task automatic write_payload(logic [CFG_W-1:0] v);
        msg_ch.valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_payload(v);
    endtask

    task automatic ready_level(logic v, int n);
        if (n > 0)
        begin
            pkt_ch.ready <= v;
            repeat (n) @(posedge clk);
        end
    endtask

    initial
    begin
        pkt_ch.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                ready_level(1'b0, HOLD_CYCLES);
            end
            else if (calm)
                ready_level(1'b1, 1);
            else
            begin
                ready_level(1'b1, $urandom_range(1, 16));
                ready_level(1'b0, rand_gap());
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pkt_ch.valid && pkt_ch.ready)
            sb.check_word('{pkt_ch.out_byte, pkt_ch.packet_end, pkt_ch.message_end,
                            pkt_ch.status});
    end

    always @(posedge clk)
    begin
        if ((msg_ch.valid && msg_ch.ready) || (pkt_ch.valid && pkt_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int usable;
        int r;
        logic [CFG_W-1:0] size;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        msg_ch.valid      <= 1'b0;
        msg_ch.msg_byte   <= '0;
        msg_ch.msg_length <= '0;
        calm         = 1'b0;
        hold_req     = 1'b0;
        items_done   = 0;
        quiet_cycles = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // fallback payload of 20 after reset
        send_word(8'h5A, '0);
        send_word(8'h00, 16'd2);
        send_word(8'hFF, 16'hFFFF);
        send_message(1, 1'b1);
        send_message(20, 1'b1);
        send_message(21, 1'b1);

        write_payload(CFG_W'(10));
        send_message(11, 1'b1);
        send_message(10, 1'b1);

        write_payload(CFG_W'(11));
        send_message(5, 1'b1);

        write_payload(CFG_W'(1));
        send_message(1, 1'b1);
        send_message(2, 1'b1);

        write_payload(CFG_W'(514));
        send_message(30, 1'b1);

        // hold the receiver off while small fragments pile up
        write_payload(CFG_W'(11));
        hold_req = 1'b1;
        send_message(8, 1'b0);

        while (items_done < ITEM_TARGET)
        begin
            case ($urandom_range(0, 7))
                0:       size = '0;
                1:       size = CFG_W'($urandom_range(1, 10));
                2:       size = CFG_W'(11);
                3:       size = CFG_W'($urandom_range(12, 40));
                4:       size = CFG_W'(514);
                5:       size = CFG_W'($urandom_range(41, 513));
                default: size = CFG_W'($urandom_range(11, 30));
            endcase
            write_payload(size);
            calm   = ($urandom_range(0, 4) == 0);
            usable = (size != 0) ? int'(size) : int'(FALLBACK_PAYLOAD);
            repeat ($urandom_range(1, 4))
            begin
                if (items_done < ITEM_TARGET)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        send_word(BYTE_W'($urandom), '0);
                    else if (r < 6 || usable > 40)
                        send_message($urandom_range(1, (usable < 24) ? usable : 24), 1'b1);
                    else
                        send_message(usable + $urandom_range(1, 16), 1'b1);
                end
            end
        end
        calm = 1'b0;

        // open an over-long message; its dropped words are never sent
        if ($urandom_range(0, 1) == 0)
            send_word(BYTE_W'($urandom), LEN_W'(MAX_MSG_LEN + 1));
        else
            send_word(BYTE_W'($urandom), 16'hFFFF);

        msg_ch.valid <= 1'b0;
        while (sb.expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
